>>> rtl/sfpa_pkg.sv
// Shared opcodes, constants and stage payload types for the saturating fixed-point ALU.
package sfpa_pkg;

    localparam int OpWidth   = 4;
    localparam int Word32    = 32;
    localparam int Word16    = 16;
    localparam int SumWidth  = 34;
    localparam int ShWidth   = 64;
    localparam int AmtWidth  = 6;
    localparam int CntWidth  = 17;
    localparam int InBytes   = 13;
    localparam int OutBytes  = 4;

    localparam logic signed [31:0] SAT32_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT32_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] SAT16_MAX  = 32'sh0000_7fff;
    localparam logic signed [31:0] SAT16_MIN  = 32'shffff_8000;
    localparam logic signed [31:0] MULT_EDGE  = 32'sh4000_0000;
    localparam logic [AmtWidth-1:0] LEFT_CLAMP  = 6'd32;
    localparam logic [AmtWidth-1:0] RIGHT_CLAMP = 6'd31;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MULT   = 4'd2,
        OP_MULT0  = 4'd3,
        OP_MAC    = 4'd4,
        OP_MSU0   = 4'd5,
        OP_LSHL   = 4'd6,
        OP_LSHR   = 4'd7,
        OP_SHL16  = 4'd8,
        OP_SHR16  = 4'd9,
        OP_NORM16 = 4'd10,
        OP_NORM32 = 4'd11,
        OP_LOW    = 4'd12,
        OP_HIGH   = 4'd13
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [31:0]       a;
        logic signed [31:0]       b;
        logic signed [15:0]       x;
        logic signed [31:0]       prod;
        logic                     shl_dir;
        logic [AmtWidth-1:0]      amt;
    } s1_t;

    typedef struct packed {
        op_t                      op;
        logic signed [SumWidth-1:0] sum;
        logic signed [ShWidth-1:0]  shifted;
        logic signed [31:0]       direct;
    } s2_t;

endpackage

>>> rtl/sfpa_prep.sv
// First stage: operand unpacking, 16 by 16 multiply and shift direction and amount.
module sfpa_prep
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sfpa_pkg::InBytes*8-1:0] in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sfpa_pkg::s1_t                  out_data
);
    import sfpa_pkg::*;

    logic                       valid_reg;
    s1_t                        data_reg;
    s1_t                        data_next;
    op_t                        op;
    logic signed [15:0]         y;
    logic signed [CntWidth-1:0] count;
    logic signed [CntWidth-1:0] neg_count;

    always_comb
    begin
        op        = op_t'(in_data[3:0]);
        y         = in_data[99:84];
        if ((op == OP_LSHR) || (op == OP_SHR16))
        begin
            count = -CntWidth'(y);
        end
        else
        begin
            count = CntWidth'(y);
        end
        neg_count = -count;

        data_next.op   = op;
        data_next.a    = in_data[35:4];
        data_next.b    = in_data[67:36];
        data_next.x    = in_data[83:68];
        data_next.prod = 32'(data_next.x * y);
        data_next.shl_dir = (count > 0);
        if (count > 0)
        begin
            data_next.amt = (count > CntWidth'(LEFT_CLAMP)) ? LEFT_CLAMP
                                                            : count[AmtWidth-1:0];
        end
        else
        begin
            data_next.amt = (neg_count > CntWidth'(RIGHT_CLAMP)) ? RIGHT_CLAMP
                                                                 : neg_count[AmtWidth-1:0];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/sfpa_exec.sv
// Second stage: wide add, barrel shift, normalisation count and word extraction.
module sfpa_exec
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sfpa_pkg::s1_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sfpa_pkg::s2_t out_data
);
    import sfpa_pkg::*;

    logic                       valid_reg;
    s2_t                        data_reg;
    s2_t                        data_next;
    logic signed [31:0]         shval;
    logic signed [ShWidth-1:0]  ext;
    logic signed [31:0]         m2;
    logic signed [SumWidth-1:0] addend;
    logic [31:0]                nword;
    logic                       nzero;
    logic [AmtWidth-1:0]        ncount;

    function automatic logic [AmtWidth-1:0] sign_run(input logic [31:0] w);
        logic [AmtWidth-1:0] c;
        logic                run;
        c   = '0;
        run = 1'b1;
        for (int i = 30; i >= 0; i--)
        begin
            if (run && (w[i] == w[31]))
            begin
                c = c + 6'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
        return c;
    endfunction

    always_comb
    begin
        if ((in_data.op == OP_SHL16) || (in_data.op == OP_SHR16))
        begin
            shval = 32'(in_data.x);
        end
        else
        begin
            shval = in_data.a;
        end
        ext = ShWidth'(shval);

        m2 = (in_data.prod == MULT_EDGE) ? SAT32_MAX : (in_data.prod <<< 1);

        case (in_data.op)
            OP_ADD:  addend = SumWidth'(in_data.b);
            OP_SUB:  addend = -SumWidth'(in_data.b);
            OP_MAC:  addend = SumWidth'(m2);
            OP_MSU0: addend = -SumWidth'(in_data.prod);
            default: addend = '0;
        endcase

        if (in_data.op == OP_NORM16)
        begin
            nword = {in_data.x, ~in_data.x[15], 15'b0};
            nzero = (in_data.x == 16'sd0);
        end
        else
        begin
            nword = in_data.a;
            nzero = (in_data.a == 32'sd0);
        end
        ncount = nzero ? '0 : sign_run(nword);

        data_next.op  = in_data.op;
        data_next.sum = SumWidth'(in_data.a) + addend;
        if (in_data.shl_dir)
        begin
            data_next.shifted = ext <<< in_data.amt;
        end
        else
        begin
            data_next.shifted = ext >>> in_data.amt;
        end

        case (in_data.op)
            OP_MULT:   data_next.direct = m2;
            OP_MULT0:  data_next.direct = in_data.prod;
            OP_NORM16: data_next.direct = 32'(ncount);
            OP_NORM32: data_next.direct = 32'(ncount);
            OP_LOW:    data_next.direct = 32'(signed'(in_data.a[15:0]));
            OP_HIGH:   data_next.direct = 32'(signed'(in_data.a[31:16]));
            default:   data_next.direct = '0;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/sfpa_sat.sv
// Third stage: saturation, result selection and the output register.
module sfpa_sat
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sfpa_pkg::s2_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_result
);
    import sfpa_pkg::*;

    logic               valid_reg;
    logic signed [31:0] result_reg;
    logic signed [31:0] result_next;
    logic signed [31:0] sum_sat;
    logic signed [31:0] sh32_sat;
    logic signed [31:0] sh16_sat;

    always_comb
    begin
        if (in_data.sum[SumWidth-1:31] == {(SumWidth-31){in_data.sum[SumWidth-1]}})
        begin
            sum_sat = in_data.sum[31:0];
        end
        else
        begin
            sum_sat = in_data.sum[SumWidth-1] ? SAT32_MIN : SAT32_MAX;
        end

        if (in_data.shifted[ShWidth-1:31] == {(ShWidth-31){in_data.shifted[ShWidth-1]}})
        begin
            sh32_sat = in_data.shifted[31:0];
        end
        else
        begin
            sh32_sat = in_data.shifted[ShWidth-1] ? SAT32_MIN : SAT32_MAX;
        end

        if (in_data.shifted[ShWidth-1:15] == {(ShWidth-15){in_data.shifted[ShWidth-1]}})
        begin
            sh16_sat = in_data.shifted[31:0];
        end
        else
        begin
            sh16_sat = in_data.shifted[ShWidth-1] ? SAT16_MIN : SAT16_MAX;
        end

        case (in_data.op)
            OP_ADD, OP_SUB, OP_MAC, OP_MSU0: result_next = sum_sat;
            OP_LSHL, OP_LSHR:                result_next = sh32_sat;
            OP_SHL16, OP_SHR16:              result_next = sh16_sat;
            default:                         result_next = in_data.direct;
        endcase
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> rtl/saturating_fixed_point_alu_top.sv
// Top level of the saturating fixed-point ALU with its stream ports.
//
// Each slave-side transaction carries one operation: an opcode, two 32-bit
// operands and two 16-bit operands, of which the second is also the signed
// shift count. Each operation yields exactly one master-side transaction
// holding the 32-bit result, with 16-bit results sign-extended.
// The datapath is three register stages: operand unpacking and the 16 by 16
// multiply, then the wide add, barrel shift and normalisation count, then
// saturation into the output register. An accepted transaction moves from the
// unpacking register through the add and shift register into the output
// register, and one operation is accepted every cycle while the master side
// keeps tready high.
// Each stage holds its own valid bit and advances whenever it is empty or
// the stage after it advances, so a stall on the master side fills the
// pipeline without losing or repeating anything, and empty stages keep
// taking new transactions until it is full.
// Reset empties the pipeline; no result is presented until new input arrives.
module saturating_fixed_point_alu_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op[3:0], in_a32[35:4], in_b32[67:36], in_x16[83:68], in_y16[99:84], zero fill.
    input  logic [sfpa_pkg::InBytes*8-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result[31:0].
    output logic [sfpa_pkg::OutBytes*8-1:0] m_tdata
);
    import sfpa_pkg::*;

    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;

    sfpa_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    sfpa_exec u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    sfpa_sat u_sat
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s2_ready),
        .in_data    (s2_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata)
    );

endmodule
